// ===== hw/rtl/casl_pkg.sv =====
// Package for the cascaded angle servo loop: sequencer states,
// multiplier phase codes, register indexes and saturation helpers. No dependencies.
package casl_pkg;

   // width of the wide sums formed around the shift-add multiplier
   localparam int SumW  = 52;
   // width of the shift-add product accumulator
   localparam int ProdW = 51;
   // gain bits, one consumed per multiplier cycle
   localparam int GainW = 16;

   localparam logic signed [31:0] CalVelCmd = -32'sd1310720;
   localparam logic signed [SumW-1:0] HalfDrvHi = 52'sd16384;
   localparam logic signed [SumW-1:0] HalfDrvLo = -52'sd16384;
   localparam logic signed [SumW-1:0] FullDrvHi = 52'sd32767;
   localparam logic signed [SumW-1:0] FullDrvLo = -52'sd32768;

   typedef enum logic [2:0] {
      RegLowerStop = 3'd0,
      RegUpperStop = 3'd1,
      RegRampUp    = 3'd2,
      RegRampDown  = 3'd3,
      RegPosGain   = 3'd4,
      RegFfGain    = 3'd5,
      RegLoopGain  = 3'd6,
      RegLeadTime  = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CAPT,
      S_RAMP,
      S_DIFF,
      S_MUL,
      S_POST,
      S_VERR,
      S_OUT
   } state_type;

   // which product the shared multiplier is forming
   typedef enum logic [1:0] {
      PH_FF,
      PH_PG,
      PH_LT,
      PH_LG
   } mphase_type;

   // saturate a wide signed sum to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] x);
      logic signed [31:0] r;
      if (x > 52'sh0_0000_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (x < -52'sh0_0000_8000_0000)
         r = -32'sh8000_0000;
      else
         r = x[31:0];
      return r;
   endfunction

endpackage

// ===== hw/rtl/cascaded_angle_servo_loop_unit.sv =====
// Top level of the cascaded angle servo loop (position loop around a velocity PI loop).
// Uses casl_pkg for states, register indexes and saturation.
//
// channel   direction  words                     fields (low bit up)
// req_      in         one per servo tick        raw_angle, new_goal, goal_load, recalibrate
// rsp_      out        one per accepted req word drive, setpoint, at_goal, calibrating
// csr_      in/out     register write/read       eight loop settings at 4*index
//
// Each tick runs four products on one shift-add multiplier, one gain bit per cycle,
// plus sequencing states. While calibrating the position gain product is skipped.
// A new req word is taken once the previous result sits in the rsp register.
// The rsp register holds its word while rsp_tready is low; the next tick runs
// up to its final step meanwhile. Reset is synchronous and puts the loop in
// calibration with the loop state cleared and the registers at their defaults.
module cascaded_angle_servo_loop_unit
   import casl_pkg::*;
#(
   parameter int VEL_LOW     = -655360,
   parameter int VEL_HIGH    = 655360,
   parameter int INT_LOW     = -655360,
   parameter int INT_HIGH    = 655360,
   parameter int CALIB_TICKS = 50,
   parameter int GOAL_WINDOW = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // raw_angle[31:0], new_goal[63:32], goal_load[64], recalibrate[65], zero[71:66]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive[15:0], setpoint[47:16], at_goal[48], calibrating[49], zero[55:50]
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic signed [32:0] VelLo = 33'(VEL_LOW);
   localparam logic signed [32:0] VelHi = 33'(VEL_HIGH);
   localparam logic signed [33:0] IntLo = 34'(INT_LOW);
   localparam logic signed [33:0] IntHi = 34'(INT_HIGH);
   localparam logic [15:0] CalibTicks = 16'(CALIB_TICKS);
   localparam logic [33:0] GoalWin = 34'(GOAL_WINDOW);

   // configuration registers
   logic signed [31:0] lower_ff, upper_ff;
   logic [30:0] up_step_ff, down_step_ff;
   logic [15:0] pos_gain_ff, ff_gain_ff, loop_gain_ff, lead_ff;

   // loop state
   logic signed [31:0] offset_ff, offset_in, goal_ff, goal_in, ramp_ff, ramp_in;
   logic signed [31:0] prev_sp_ff, prev_sp_in, prev_ang_ff, prev_ang_in;
   logic signed [31:0] integ_ff, integ_in;
   logic [15:0] tick_ff, tick_in;
   logic cal_ff, cal_in;

   // captured word and working values
   logic signed [31:0] raw_ff, raw_in, new_goal_ff, new_goal_in;
   logic load_ff, load_in, recal_ff, recal_in;
   logic signed [31:0] angle_ff, angle_in, vel_ff, vel_in, vcmd_ff, vcmd_in;
   logic at_goal_ff, at_goal_in;
   logic signed [15:0] drive_ff, drive_in;

   // shift-add multiplier
   logic signed [ProdW-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [GainW-1:0] mplier_ff, mplier_in;
   logic [3:0] cnt_ff, cnt_in;
   mphase_type phase_ff, phase_in;

   state_type state_ff, state_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff     <= '0;
         upper_ff     <= 32'sd6553600;
         up_step_ff   <= 31'd65536;
         down_step_ff <= 31'd65536;
         pos_gain_ff  <= 16'd256;
         ff_gain_ff   <= '0;
         loop_gain_ff <= 16'd256;
         lead_ff      <= 16'd256;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_index_type'(csr_paddr[4:2]))
            RegLowerStop: lower_ff     <= csr_pwdata;
            RegUpperStop: upper_ff     <= csr_pwdata;
            RegRampUp:    up_step_ff   <= csr_pwdata[30:0];
            RegRampDown:  down_step_ff <= csr_pwdata[30:0];
            RegPosGain:   pos_gain_ff  <= csr_pwdata[15:0];
            RegFfGain:    ff_gain_ff   <= csr_pwdata[15:0];
            RegLoopGain:  loop_gain_ff <= csr_pwdata[15:0];
            RegLeadTime:  lead_ff      <= csr_pwdata[15:0];
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_index_type'(csr_paddr[4:2]))
         RegLowerStop: csr_prdata = lower_ff;
         RegUpperStop: csr_prdata = upper_ff;
         RegRampUp:    csr_prdata = {1'b0, up_step_ff};
         RegRampDown:  csr_prdata = {1'b0, down_step_ff};
         RegPosGain:   csr_prdata = {16'd0, pos_gain_ff};
         RegFfGain:    csr_prdata = {16'd0, ff_gain_ff};
         RegLoopGain:  csr_prdata = {16'd0, loop_gain_ff};
         RegLeadTime:  csr_prdata = {16'd0, lead_ff};
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= '0;
         goal_ff      <= '0;
         ramp_ff      <= '0;
         prev_sp_ff   <= '0;
         prev_ang_ff  <= '0;
         integ_ff     <= '0;
         tick_ff      <= '0;
         cal_ff       <= 1'b1;
         phase_ff     <= PH_FF;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         goal_ff      <= goal_in;
         ramp_ff      <= ramp_in;
         prev_sp_ff   <= prev_sp_in;
         prev_ang_ff  <= prev_ang_in;
         integ_ff     <= integ_in;
         tick_ff      <= tick_in;
         cal_ff       <= cal_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      new_goal_ff <= new_goal_in;
      load_ff     <= load_in;
      recal_ff    <= recal_in;
      angle_ff    <= angle_in;
      vel_ff      <= vel_in;
      vcmd_ff     <= vcmd_in;
      at_goal_ff  <= at_goal_in;
      drive_ff    <= drive_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      logic signed [31:0] goal_v, angle_v;
      logic [15:0] tick_v;
      logic cal_v;
      logic signed [32:0] d33, step33, up33, dn33;
      logic signed [SumW-1:0] s52, acc52;
      logic signed [33:0] i34, g34, verr_v;
      logic [33:0] abs34;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      offset_in    = offset_ff;
      goal_in      = goal_ff;
      ramp_in      = ramp_ff;
      prev_sp_in   = prev_sp_ff;
      prev_ang_in  = prev_ang_ff;
      integ_in     = integ_ff;
      tick_in      = tick_ff;
      cal_in       = cal_ff;
      raw_in       = raw_ff;
      new_goal_in  = new_goal_ff;
      load_in      = load_ff;
      recal_in     = recal_ff;
      angle_in     = angle_ff;
      vel_in       = vel_ff;
      vcmd_in      = vcmd_ff;
      at_goal_in   = at_goal_ff;
      drive_in     = drive_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      goal_v  = goal_ff;
      angle_v = angle_ff;
      tick_v  = tick_ff;
      cal_v   = cal_ff;
      d33     = '0;
      step33  = '0;
      up33    = $signed({2'b00, up_step_ff});
      dn33    = -$signed({2'b00, down_step_ff});
      acc52   = {acc_ff[ProdW-1], acc_ff};
      s52     = '0;
      i34     = '0;
      g34     = '0;
      verr_v  = '0;
      abs34   = '0;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               raw_in      = req_tdata[31:0];
               new_goal_in = req_tdata[63:32];
               load_in     = req_tdata[64];
               recal_in    = req_tdata[65];
               state_in    = S_CAPT;
            end
         end

         // goal load, recalibrate, angle, stop clamp and calibration end
         S_CAPT: begin
            if (load_ff)
               goal_v = new_goal_ff;
            if (recal_ff && !cal_ff) begin
               cal_v  = 1'b1;
               tick_v = '0;
            end
            angle_v = raw_ff - offset_ff;
            if (goal_v > upper_ff)
               goal_v = upper_ff;
            if (goal_v < lower_ff)
               goal_v = lower_ff;
            if (cal_v && (tick_v > CalibTicks) && (angle_v == prev_ang_ff)) begin
               cal_v       = 1'b0;
               offset_in   = raw_ff;
               angle_v     = '0;
               goal_v      = '0;
               ramp_in     = '0;
               prev_sp_in  = '0;
               prev_ang_in = '0;
               integ_in    = '0;
            end
            if (tick_v != 16'hFFFF)
               tick_v = tick_v + 16'd1;
            goal_in  = goal_v;
            angle_in = angle_v;
            tick_in  = tick_v;
            cal_in   = cal_v;
            state_in = S_RAMP;
         end

         // rate-limited setpoint step and clamped velocity
         S_RAMP: begin
            d33 = {goal_ff[31], goal_ff} - {ramp_ff[31], ramp_ff};
            step33 = d33;
            if (step33 > up33)
               step33 = up33;
            if (step33 < dn33)
               step33 = dn33;
            ramp_in = ramp_ff + step33[31:0];
            d33 = {angle_ff[31], angle_ff} - {prev_ang_ff[31], prev_ang_ff};
            if (d33 > VelHi)
               d33 = VelHi;
            if (d33 < VelLo)
               d33 = VelLo;
            vel_in   = d33[31:0];
            state_in = S_DIFF;
         end

         // setpoint rate into the multiplier for feedforward
         S_DIFF: begin
            d33       = {ramp_ff[31], ramp_ff} - {prev_sp_ff[31], prev_sp_ff};
            mcand_in  = ProdW'(d33);
            mplier_in = ff_gain_ff;
            acc_in    = '0;
            cnt_in    = '0;
            phase_in  = PH_FF;
            state_in  = S_MUL;
         end

         // one gain bit per cycle
         S_MUL: begin
            if (mplier_ff[0])
               acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15)
               state_in = S_POST;
         end

         S_POST: begin
            unique case (phase_ff)
               // position error, then the position gain product (the calibration velocity command while calibrating)
               PH_FF: begin
                  s52 = SumW'(ramp_ff) + (acc52 >>> 8) - SumW'(angle_ff);
                  if (cal_ff) begin
                     vcmd_in  = CalVelCmd;
                     state_in = S_VERR;
                  end else begin
                     mcand_in  = ProdW'(sat32(s52));
                     mplier_in = pos_gain_ff;
                     acc_in    = '0;
                     cnt_in    = '0;
                     phase_in  = PH_PG;
                     state_in  = S_MUL;
                  end
               end
               PH_PG: begin
                  vcmd_in  = sat32(acc52 >>> 8);
                  state_in = S_VERR;
               end
               // inner command, then the drive scale product
               PH_LT: begin
                  s52       = (acc52 >>> 8) + SumW'(integ_ff);
                  mcand_in  = ProdW'(sat32(s52));
                  mplier_in = loop_gain_ff;
                  acc_in    = '0;
                  cnt_in    = '0;
                  phase_in  = PH_LG;
                  state_in  = S_MUL;
               end
               // drive saturation and end of tick
               PH_LG: begin
                  s52 = acc52 >>> 9;
                  if (cal_ff) begin
                     if (s52 > HalfDrvHi)
                        s52 = HalfDrvHi;
                     if (s52 < HalfDrvLo)
                        s52 = HalfDrvLo;
                  end else begin
                     if (s52 > FullDrvHi)
                        s52 = FullDrvHi;
                     if (s52 < FullDrvLo)
                        s52 = FullDrvLo;
                  end
                  drive_in    = s52[15:0];
                  prev_ang_in = angle_ff;
                  prev_sp_in  = ramp_ff;
                  state_in    = S_OUT;
               end
            endcase
         end

         // velocity error, integrator and goal window, then the lead time product
         S_VERR: begin
            verr_v = 34'(vcmd_ff) - 34'(vel_ff);
            i34 = verr_v + 34'(integ_ff);
            if (i34 > IntHi)
               i34 = IntHi;
            if (i34 < IntLo)
               i34 = IntLo;
            integ_in = i34[31:0];
            g34   = 34'(goal_ff) - 34'(angle_ff);
            abs34 = g34[33] ? unsigned'(-g34) : unsigned'(g34);
            at_goal_in = !cal_ff && (abs34 <= GoalWin);
            mcand_in  = ProdW'(verr_v);
            mplier_in = lead_ff;
            acc_in    = '0;
            cnt_in    = '0;
            phase_in  = PH_LT;
            state_in  = S_MUL;
         end

         // hand the word to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, cal_ff, at_goal_ff, ramp_ff, drive_ff};
               state_in     = S_IDLE;
            end
         end
      endcase
   end

endmodule
